FILE: rtl/dd_pkg.sv
`timescale 1ns / 1ps

package dd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned ORD_W   = 23;
  localparam int unsigned DBM_W   = 9;

  // x / 25 for x below 2**12 as (x * 5243) >> 17
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned PROD_W      = 25;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned QUOT_W      = 8;
  localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;

  localparam int unsigned REM_W = 7;
  localparam logic [YEAR_W-1:0] CENTURY = 14'd100;
  localparam logic [ORD_W-1:0] DAYS_PER_YEAR = 23'd365;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  prev_year;
  } clamp_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  prev_year;
    logic [ORD_W-1:0]   years_days;
    logic [PROD_W-1:0]  prod_prev;
    logic [PROD_W-1:0]  prod_year;
  } mult_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic               year_div4;
    logic [ORD_W-1:0]   base;
    logic [QUOT_W-1:0]  cent_prev;
    logic [QUOT_W-1:0]  cent_year;
    logic [REM_W-1:0]   rem_year;
  } quot_t;

  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/date_difference_days_top.sv
`timescale 1ns / 1ps
// throughput: one item per cycle, five register stages, stalls freeze the whole pipe
// stall_o follows stall_i while the output register holds an untaken result
// reset: rst_ni asynchronous active low, clears all stage valid bits
// payload registers are not reset

module date_difference_days_top #(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [dd_pkg::DAY_W-1:0]   first_day_i,
  input  logic [dd_pkg::MONTH_W-1:0] first_month_i,
  input  logic [dd_pkg::YEAR_W-1:0]  first_year_i,
  input  logic [dd_pkg::DAY_W-1:0]   second_day_i,
  input  logic [dd_pkg::MONTH_W-1:0] second_month_i,
  input  logic [dd_pkg::YEAR_W-1:0]  second_year_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [dd_pkg::DIFF_W-1:0]  day_difference_o
);

  localparam int unsigned YearLimit = (1 << dd_pkg::YEAR_W) - 1;
  localparam int unsigned YearCap   = (YEAR_MAX > YearLimit) ? YearLimit : YEAR_MAX;
  localparam logic [dd_pkg::YEAR_W-1:0] YearCapW = dd_pkg::YEAR_W'(YearCap);
  localparam int unsigned Stages = 5;

  logic [Stages-1:0] valid_d, valid_q;
  logic              adv;

  dd_pkg::date_t  in_date [2];
  dd_pkg::clamp_t s1_d [2], s1_q [2];
  dd_pkg::mult_t  s2_d [2], s2_q [2];
  dd_pkg::quot_t  s3_d [2], s3_q [2];
  logic [dd_pkg::ORD_W-1:0]  s4_d [2], s4_q [2];
  logic [dd_pkg::DIFF_W-1:0] diff_d, diff_q;

  logic [dd_pkg::ORD_W:0]    diff_wide;

  assign adv     = !(valid_q[Stages-1] && stall_i);
  assign stall_o = !adv;
  assign valid_o = valid_q[Stages-1];
  assign day_difference_o = diff_q;

  assign in_date[0] = '{day: first_day_i, month: first_month_i, year: first_year_i};
  assign in_date[1] = '{day: second_day_i, month: second_month_i, year: second_year_i};

  // clamp month and year, the day passes through
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s1_d[i].day = in_date[i].day;
      if (in_date[i].month < dd_pkg::MONTH_JAN) begin
        s1_d[i].month = dd_pkg::MONTH_JAN;
      end else if (in_date[i].month > dd_pkg::MONTH_DEC) begin
        s1_d[i].month = dd_pkg::MONTH_DEC;
      end else begin
        s1_d[i].month = in_date[i].month;
      end
      if (in_date[i].year == '0) begin
        s1_d[i].year = dd_pkg::YEAR_W'(1);
      end else if (in_date[i].year > YearCapW) begin
        s1_d[i].year = YearCapW;
      end else begin
        s1_d[i].year = in_date[i].year;
      end
      s1_d[i].prev_year = s1_d[i].year - dd_pkg::YEAR_W'(1);
    end
  end

  // products for whole years and division by 100
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s2_d[i].day        = s1_q[i].day;
      s2_d[i].month      = s1_q[i].month;
      s2_d[i].year       = s1_q[i].year;
      s2_d[i].prev_year  = s1_q[i].prev_year;
      s2_d[i].years_days = dd_pkg::ORD_W'(s1_q[i].prev_year) * dd_pkg::DAYS_PER_YEAR;
      s2_d[i].prod_prev  = dd_pkg::PROD_W'(s1_q[i].prev_year[dd_pkg::YEAR_W-1:2])
                           * dd_pkg::PROD_W'(dd_pkg::RECIP_25);
      s2_d[i].prod_year  = dd_pkg::PROD_W'(s1_q[i].year[dd_pkg::YEAR_W-1:2])
                           * dd_pkg::PROD_W'(dd_pkg::RECIP_25);
    end
  end

  // quotients, century remainder, base day count
  always_comb begin
    logic [dd_pkg::YEAR_W-1:0] rem_full;
    rem_full = '0;
    for (int i = 0; i < 2; i++) begin
      s3_d[i].day       = s2_q[i].day;
      s3_d[i].month     = s2_q[i].month;
      s3_d[i].year_div4 = (s2_q[i].year[1:0] == 2'd0);
      s3_d[i].cent_prev = s2_q[i].prod_prev[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
      s3_d[i].cent_year = s2_q[i].prod_year[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];
      rem_full = s2_q[i].year - dd_pkg::YEAR_W'(s3_d[i].cent_year) * dd_pkg::CENTURY;
      s3_d[i].rem_year  = rem_full[dd_pkg::REM_W-1:0];
      s3_d[i].base      = s2_q[i].years_days
                          + dd_pkg::ORD_W'(s2_q[i].prev_year[dd_pkg::YEAR_W-1:2]);
    end
  end

  // day ordinal of each date
  always_comb begin
    logic leap;
    leap = 1'b0;
    for (int i = 0; i < 2; i++) begin
      leap = s3_q[i].year_div4
             && ((s3_q[i].rem_year != '0) || (s3_q[i].cent_year[1:0] == 2'd0));
      s4_d[i] = s3_q[i].base
                - dd_pkg::ORD_W'(s3_q[i].cent_prev)
                + dd_pkg::ORD_W'(s3_q[i].cent_prev[dd_pkg::QUOT_W-1:2])
                + dd_pkg::ORD_W'(dd_pkg::days_before_month(s3_q[i].month))
                + dd_pkg::ORD_W'(leap && (s3_q[i].month > dd_pkg::MONTH_FEB))
                + dd_pkg::ORD_W'(s3_q[i].day);
    end
  end

  // difference with saturation
  always_comb begin
    diff_wide = {1'b0, s4_q[1]} - {1'b0, s4_q[0]};
    if (diff_wide[dd_pkg::ORD_W] != diff_wide[dd_pkg::ORD_W-1]) begin
      diff_d = {diff_wide[dd_pkg::ORD_W], {(dd_pkg::DIFF_W-1){!diff_wide[dd_pkg::ORD_W]}}};
    end else begin
      diff_d = diff_wide[dd_pkg::DIFF_W-1:0];
    end
  end

  assign valid_d = {valid_q[Stages-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      s3_q   <= s3_d;
      s4_q   <= s4_d;
      diff_q <= diff_d;
    end
  end

endmodule

FILE: rtl/dd_checker.sv
`timescale 1ns / 1ps

module dd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      valid_i,
  input logic                      stall_o,
  input logic [dd_pkg::DAY_W-1:0]   first_day_i,
  input logic [dd_pkg::MONTH_W-1:0] first_month_i,
  input logic [dd_pkg::YEAR_W-1:0]  first_year_i,
  input logic [dd_pkg::DAY_W-1:0]   second_day_i,
  input logic [dd_pkg::MONTH_W-1:0] second_month_i,
  input logic [dd_pkg::YEAR_W-1:0]  second_year_i,
  input logic                      valid_o,
  input logic                      stall_i,
  input logic [dd_pkg::DIFF_W-1:0]  day_difference_o
);

  logic same_date_acc;

  assign same_date_acc = valid_i && !stall_o
                         && (first_day_i == second_day_i)
                         && (first_month_i == second_month_i)
                         && (first_year_i == second_year_i);

  a_valid_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result item dropped while stalled");

  a_payload_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(day_difference_o))
    else $error("stalled result item changed");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled with no waiting result item");

  a_same_date_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    same_date_acc ##1 !stall_i ##1 !stall_i ##1 !stall_i ##1 !stall_i
    |=> valid_o && (day_difference_o == '0))
    else $error("equal dates gave a nonzero difference");

endmodule

bind date_difference_days_top dd_checker u_dd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (valid_i),
  .stall_o          (stall_o),
  .first_day_i      (first_day_i),
  .first_month_i    (first_month_i),
  .first_year_i     (first_year_i),
  .second_day_i     (second_day_i),
  .second_month_i   (second_month_i),
  .second_year_i    (second_year_i),
  .valid_o          (valid_o),
  .stall_i          (stall_i),
  .day_difference_o (day_difference_o)
);

FILE: tb/tb_date_difference_days_top.sv
`timescale 1ns / 1ps

module tb_date_difference_days_top;

  localparam int unsigned YEAR_LIMIT = 9999;
  localparam longint DIFF_HI = 4194303;
  localparam longint DIFF_LO = -4194304;
  localparam int unsigned TAIL_CYCLES = 12;

  localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int DAYS_AHEAD [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o;
  logic valid_o;
  logic [dd_pkg::DAY_W-1:0]   first_day_i = '0;
  logic [dd_pkg::MONTH_W-1:0] first_month_i = '0;
  logic [dd_pkg::YEAR_W-1:0]  first_year_i = '0;
  logic [dd_pkg::DAY_W-1:0]   second_day_i = '0;
  logic [dd_pkg::MONTH_W-1:0] second_month_i = '0;
  logic [dd_pkg::YEAR_W-1:0]  second_year_i = '0;
  logic [dd_pkg::DIFF_W-1:0]  day_difference_o;

  logic [dd_pkg::DIFF_W-1:0] expected_diff_q [$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic hold_on = 1'b0;
  int unsigned errors = 0;
  int unsigned pairs_sent = 0;
  int unsigned diffs_checked = 0;

  date_difference_days_top #(
    .YEAR_MAX(YEAR_LIMIT)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .first_day_i     (first_day_i),
    .first_month_i   (first_month_i),
    .first_year_i    (first_year_i),
    .second_day_i    (second_day_i),
    .second_month_i  (second_month_i),
    .second_year_i   (second_year_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .day_difference_o(day_difference_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit leap_year(input longint yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic longint day_number(input dd_pkg::date_t dt);
    longint yr;
    longint py;
    longint n;
    int mo;
    yr = longint'(dt.year);
    if (yr < 1) yr = 1;
    if (yr > YEAR_LIMIT) yr = YEAR_LIMIT;
    mo = int'(dt.month);
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    py = yr - 1;
    n = 365 * py + py / 4 - py / 100 + py / 400 + DAYS_AHEAD[mo-1];
    if (mo > 2 && leap_year(yr)) n = n + 1;
    n = n + longint'(dt.day);
    return n;
  endfunction

  function automatic logic [dd_pkg::DIFF_W-1:0] predict_difference(
    input dd_pkg::date_t from_date,
    input dd_pkg::date_t to_date
  );
    longint span;
    span = day_number(to_date) - day_number(from_date);
    if (span > DIFF_HI) span = DIFF_HI;
    if (span < DIFF_LO) span = DIFF_LO;
    return span[dd_pkg::DIFF_W-1:0];
  endfunction

  function automatic dd_pkg::date_t make_date(input int d, input int m, input int y);
    dd_pkg::date_t dt;
    dt.day = d[dd_pkg::DAY_W-1:0];
    dt.month = m[dd_pkg::MONTH_W-1:0];
    dt.year = y[dd_pkg::YEAR_W-1:0];
    return dt;
  endfunction

  function automatic int month_length(input int m, input int y);
    if (m == 2 && leap_year(y)) return 29;
    return MONTH_LEN[m-1];
  endfunction

  function automatic dd_pkg::date_t random_valid_date();
    int y;
    int m;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) y = 100 * $urandom_range(1, YEAR_LIMIT / 100);
    else if (pick < 20) y = 4 * $urandom_range(1, YEAR_LIMIT / 4);
    else y = $urandom_range(1, YEAR_LIMIT);
    if (pick < 20 && $urandom_range(1)) m = $urandom_range(2, 3);
    else m = $urandom_range(1, 12);
    return make_date($urandom_range(1, month_length(m, y)), m, y);
  endfunction

  function automatic dd_pkg::date_t random_raw_date();
    dd_pkg::date_t dt;
    dt.day = dd_pkg::DAY_W'($urandom_range(0, 31));
    dt.month = dd_pkg::MONTH_W'($urandom_range(0, 15));
    dt.year = dd_pkg::YEAR_W'($urandom_range(0, 16383));
    return dt;
  endfunction

  // called at a rising edge, returns at the edge that takes the item
  task automatic send_dates(input dd_pkg::date_t from_date, input dd_pkg::date_t to_date);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i        <= 1'b1;
    first_day_i    <= from_date.day;
    first_month_i  <= from_date.month;
    first_year_i   <= from_date.year;
    second_day_i   <= to_date.day;
    second_month_i <= to_date.month;
    second_year_i  <= to_date.year;
    @(negedge clk_i);
    while (stall_o) @(negedge clk_i);
    expected_diff_q.push_back(predict_difference(from_date, to_date));
    pairs_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    valid_i <= 1'b0;
    while (expected_diff_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    stall_i <= hold_on || ($urandom_range(99) < rx_idle_pct);
  end

  always @(negedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_diff_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d", $time,
                 $signed(day_difference_o));
        errors++;
      end else begin
        if (day_difference_o !== expected_diff_q[0]) begin
          $display("%0t day_difference mismatch: expected %0d, actual %0d", $time,
                   $signed(expected_diff_q[0]), $signed(day_difference_o));
          errors++;
        end
        void'(expected_diff_q.pop_front());
        diffs_checked++;
      end
    end
  end

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // same date, full span both ways
    send_dates(make_date(1, 1, 1), make_date(1, 1, 1));
    send_dates(make_date(1, 1, 1), make_date(31, 12, 9999));
    send_dates(make_date(31, 12, 9999), make_date(1, 1, 1));
    // leap rules around february, and a year boundary
    send_dates(make_date(28, 2, 2000), make_date(1, 3, 2000));
    send_dates(make_date(28, 2, 1900), make_date(1, 3, 1900));
    send_dates(make_date(28, 2, 2004), make_date(1, 3, 2004));
    send_dates(make_date(29, 2, 2024), make_date(28, 2, 2023));
    send_dates(make_date(31, 12, 1999), make_date(1, 1, 2000));
    // days outside the month
    send_dates(make_date(31, 4, 2021), make_date(1, 5, 2021));
    send_dates(make_date(0, 3, 2021), make_date(28, 2, 2021));
    send_dates(make_date(31, 2, 2023), make_date(3, 3, 2023));
    send_dates(make_date(0, 1, 1), make_date(31, 12, 9999));
    // months out of range
    send_dates(make_date(15, 0, 2020), make_date(15, 1, 2020));
    send_dates(make_date(1, 13, 2020), make_date(1, 12, 2020));
    send_dates(make_date(31, 15, 2020), make_date(1, 1, 2021));
    // years out of range
    send_dates(make_date(1, 1, 0), make_date(1, 1, 1));
    send_dates(make_date(1, 1, 10000), make_date(1, 1, 9999));
    send_dates(make_date(31, 15, 16383), make_date(0, 0, 0));
    send_dates(make_date(0, 0, 0), make_date(31, 15, 16383));
    send_dates(make_date(1, 1, 9999), make_date(31, 12, 16383));
    drain_results();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned tx_pct,
                             input int unsigned rx_pct);
    dd_pkg::date_t from_date;
    dd_pkg::date_t to_date;
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      from_date = random_valid_date();
      if (pick < 55) begin
        to_date = random_valid_date();
      end else if (pick < 80) begin
        to_date = random_valid_date();
        to_date.year = from_date.year;
        if (to_date.day > month_length(int'(to_date.month), int'(to_date.year))) begin
          to_date.day = dd_pkg::DAY_W'(1);
        end
      end else begin
        from_date = random_raw_date();
        to_date = random_raw_date();
      end
      send_dates(from_date, to_date);
    end
    drain_results();
  endtask

  task automatic test_output_hold();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      begin
        @(posedge clk_i);
        hold_on <= 1'b1;
        repeat (80) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    repeat (24) send_dates(random_valid_date(), random_valid_date());
    drain_results();
  endtask

  task automatic test_drain_pause();
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    repeat (8) send_dates(random_valid_date(), random_valid_date());
    drain_results();
    @(posedge clk_i);
    repeat (8) send_dates(random_raw_date(), random_valid_date());
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    @(posedge clk_i);
    test_random(370, 35, 62);
    @(posedge clk_i);
    test_random(370, 62, 35);
    @(posedge clk_i);
    test_output_hold();
    @(posedge clk_i);
    test_drain_pause();
    @(posedge clk_i);
    test_random(370, 0, 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_diff_q.size() != 0) begin
      $display("%0t %0d differences still outstanding", $time, expected_diff_q.size());
      errors++;
    end
    $display("%0d date pairs sent and %0d differences checked", pairs_sent, diffs_checked);
    $display("covering out-of-range fields, leap edges, long output hold-off and drain pause");
    if (errors == 0) begin
      $display("[date_difference_days_top] OK");
    end else begin
      $display("[date_difference_days_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d differences outstanding", expected_diff_q.size());
    $display("[date_difference_days_top] ERROR");
    $finish;
  end

endmodule
